// ===== design/mqa_pkg.sv =====
package mqa_pkg;

	localparam int SLOTS = 64;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_USE = 2'd1;
	localparam logic [1:0] CMD_FREE = 2'd2;

	localparam logic [1:0] REG_BOOST_INTERVAL = 2'd0;
	localparam logic [1:0] REG_QUANTUM_HIGH = 2'd1;
	localparam logic [1:0] REG_QUANTUM_MID = 2'd2;
	localparam logic [1:0] REG_QUANTUM_LOW = 2'd3;

	localparam logic [15:0] BOOST_INTERVAL_RST = 16'd1000;
	localparam logic [7:0] QUANTUM_HIGH_RST = 8'd4;
	localparam logic [7:0] QUANTUM_MID_RST = 8'd8;
	localparam logic [7:0] QUANTUM_LOW_RST = 8'd16;

	localparam logic [1:0] LEVEL_MAX = 2'd2;
	localparam logic [7:0] QUSED_MAX = 8'hff;

	typedef struct packed {
		logic [1:0] level;
		logic [7:0] qused;
		logic [31:0] runtime;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/mqa_ram.sv =====
module mqa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/mlfq_quantum_accounting.sv =====
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: command; tdata: slot, slot_running, boot_cpu
// m_*       out  m_tvalid/m_tready  tdata: yield_now, demoted, boosted, level_after, runtime_after
// cfg_*     in   cfg_we             cfg_index selects the register, cfg_data the value
//
// the result is registered after the update stage: the slot ram is read at the accepting
// edge, then the update stage updates, writes back and registers the result; a new beat is taken
// every cycle while the result is not stalled, set by the single ram port pair
// a write followed by a read of the same slot is forwarded from a register
// per-slot in-use, boost-pending and written flags live in flops and clear at reset,
// so the slot ram needs no clearing pass
// a stalled result holds the update stage, and the input waits behind it
module mlfq_quantum_accounting
	import mqa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // slot[5:0], slot_running[6], boot_cpu[7]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // yield_now[0], demoted[1], boosted[2], level_after[4:3],
	                               // runtime_after[36:5], zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] boost_interval_q;
	logic [7:0] quantum_high_q;
	logic [7:0] quantum_mid_q;
	logic [7:0] quantum_low_q;
	logic [15:0] boost_count_q;
	logic [SLOTS-1:0] in_use_q;
	logic [SLOTS-1:0] pend_q;
	logic [SLOTS-1:0] wrt_q;

	logic s1_valid_q;
	logic [1:0] cmd_s1;
	logic [5:0] slot_s1;
	logic running_s1;
	logic boot_s1;
	logic coll_s1;
	entry_t fwd_s1;

	logic m_tvalid_q;
	logic [39:0] m_tdata_q;

	logic accept;
	logic s1_go;
	logic [SLOT_W-1:0] idx;
	logic valid_s1;
	entry_t rd_data;
	entry_t raw;
	entry_t cur;
	entry_t nxt;
	logic [7:0] quantum;
	logic [15:0] cnt_inc;
	logic [15:0] cnt_d;
	logic [SLOTS-1:0] in_use_d;
	logic [SLOTS-1:0] pend_d;
	logic [SLOTS-1:0] wrt_d;
	logic fire;
	logic yld;
	logic dem;
	logic ram_we;

	assign s1_go = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_go;
	assign accept = s_tvalid && s_tready;
	assign idx = slot_s1[SLOT_W-1:0];
	assign valid_s1 = 32'(slot_s1) < SLOTS;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	mqa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (s1_go && ram_we),
		.waddr(idx),
		.wdata(nxt),
		.re   (accept),
		.raddr(s_tdata[SLOT_W-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		raw = coll_s1 ? fwd_s1 : rd_data;
		cur = raw;
		if (!wrt_q[idx]) begin
			cur = '0;
		end
		if (pend_q[idx]) begin
			cur.level = 2'd0;
			cur.qused = 8'd0;
		end
		nxt = cur;
		in_use_d = in_use_q;
		pend_d = pend_q;
		wrt_d = wrt_q;
		cnt_inc = boost_count_q + 16'd1;
		cnt_d = boost_count_q;
		fire = 1'b0;
		yld = 1'b0;
		dem = 1'b0;
		ram_we = 1'b0;
		quantum = quantum_low_q;
		case (cmd_s1)
			CMD_TICK: begin
				if (boot_s1) begin
					if (cnt_inc >= boost_interval_q) begin
						fire = 1'b1;
						cnt_d = 16'd0;
						pend_d = in_use_q;
						if (in_use_q[idx]) begin
							nxt.level = 2'd0;
							nxt.qused = 8'd0;
						end
					end else begin
						cnt_d = cnt_inc;
					end
				end
				if (running_s1 && valid_s1) begin
					if (nxt.qused != QUSED_MAX) begin
						nxt.qused = nxt.qused + 8'd1;
					end
					nxt.runtime = nxt.runtime + 32'd1;
					case (nxt.level)
						2'd0: quantum = quantum_high_q;
						2'd1: quantum = quantum_mid_q;
						default: quantum = quantum_low_q;
					endcase
					if (nxt.qused >= quantum) begin
						if (nxt.level < LEVEL_MAX) begin
							nxt.level = nxt.level + 2'd1;
							dem = 1'b1;
						end
						nxt.qused = 8'd0;
						yld = 1'b1;
					end
					ram_we = 1'b1;
				end
			end
			CMD_USE, CMD_FREE: begin
				if (valid_s1) begin
					in_use_d[idx] = (cmd_s1 == CMD_USE);
					nxt = '0;
					ram_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (ram_we) begin
			wrt_d[idx] = 1'b1;
			pend_d[idx] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_interval_q <= BOOST_INTERVAL_RST;
			quantum_high_q <= QUANTUM_HIGH_RST;
			quantum_mid_q <= QUANTUM_MID_RST;
			quantum_low_q <= QUANTUM_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOOST_INTERVAL: boost_interval_q <= cfg_data;
				REG_QUANTUM_HIGH: quantum_high_q <= cfg_data[7:0];
				REG_QUANTUM_MID: quantum_mid_q <= cfg_data[7:0];
				REG_QUANTUM_LOW: quantum_low_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_count_q <= '0;
			in_use_q <= '0;
			pend_q <= '0;
			wrt_q <= '0;
			s1_valid_q <= 1'b0;
			coll_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				boost_count_q <= cnt_d;
				in_use_q <= in_use_d;
				pend_q <= pend_d;
				wrt_q <= wrt_d;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
				coll_s1 <= s1_go && ram_we && (idx == s_tdata[SLOT_W-1:0]);
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= s_tuser;
			slot_s1 <= s_tdata[5:0];
			running_s1 <= s_tdata[6];
			boot_s1 <= s_tdata[7];
			fwd_s1 <= nxt;
		end
		if (s1_go) begin
			m_tdata_q <= {3'b000,
				valid_s1 ? nxt.runtime : 32'd0,
				valid_s1 ? nxt.level : 2'd0,
				fire, dem, yld};
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~in_use_q) == '0)
		else $error("boost pending on a free slot");

	a_boost_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && fire |=> boost_count_q == 16'd0)
		else $error("boost counter did not restart");

	a_demote_yields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("demotion without yield");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import mqa_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic        yield_now;
		logic        demoted;
		logic        boosted;
		logic [1:0]  level_after;
		logic [31:0] runtime_after;
	} acct_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // slot[5:0], slot_running[6], boot_cpu[7]
	logic [1:0]  s_tuser = '0;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // yield_now[0], demoted[1], boosted[2], level_after[4:3],
	                             // runtime_after[36:5], zero fill
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// scheduler shadow state
	logic [15:0] boost_interval_r;
	logic [15:0] boost_count_r;
	logic [7:0]  quantum_r [3];
	logic        in_use_r [SLOTS];
	logic [1:0]  level_r [SLOTS];
	logic [7:0]  qused_r [SLOTS];
	logic [31:0] runtime_r [SLOTS];

	acct_result_t pending_results[$];
	int           errors = 0;
	bit           gaps_on = 0;
	bit           stalls_on = 0;

	mlfq_quantum_accounting uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("mlfq_quantum_accounting verification failed");
		$finish;
	end

	function automatic void clear_scheduler();
		boost_interval_r = BOOST_INTERVAL_RST;
		quantum_r[0] = QUANTUM_HIGH_RST;
		quantum_r[1] = QUANTUM_MID_RST;
		quantum_r[2] = QUANTUM_LOW_RST;
		boost_count_r = '0;
		for (int i = 0; i < SLOTS; i++) begin
			in_use_r[i] = 1'b0;
			level_r[i] = '0;
			qused_r[i] = '0;
			runtime_r[i] = '0;
		end
	endfunction

	function automatic acct_result_t account_beat(logic [1:0] cmd, logic [SLOT_W-1:0] slot,
			logic running, logic boot);
		acct_result_t res;
		logic [7:0]   quantum;
		res = '0;
		case (cmd)
			CMD_USE, CMD_FREE: begin
				in_use_r[slot] = (cmd == CMD_USE);
				level_r[slot] = '0;
				qused_r[slot] = '0;
				runtime_r[slot] = '0;
			end
			CMD_TICK: begin
				if (boot) begin
					boost_count_r = boost_count_r + 16'd1;
					if (boost_count_r >= boost_interval_r) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (in_use_r[i]) begin
								level_r[i] = '0;
								qused_r[i] = '0;
							end
						end
						boost_count_r = '0;
						res.boosted = 1'b1;
					end
				end
				if (running) begin
					if (qused_r[slot] != QUSED_MAX)
						qused_r[slot] = qused_r[slot] + 8'd1;
					runtime_r[slot] = runtime_r[slot] + 32'd1;
					quantum = quantum_r[level_r[slot]];
					if (qused_r[slot] >= quantum) begin
						if (level_r[slot] < LEVEL_MAX) begin
							level_r[slot] = level_r[slot] + 2'd1;
							res.demoted = 1'b1;
						end
						qused_r[slot] = '0;
						res.yield_now = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.level_after = level_r[slot];
		res.runtime_after = runtime_r[slot];
		return res;
	endfunction

	function automatic int sender_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver backpressure
	initial begin : sink_ready
		int hold;
		int r;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= 1'b1;
				if (stalls_on) begin
					r = $urandom_range(0, 99);
					if (r < 17)
						hold = $urandom_range(1, 3);
					else if (r < 20)
						hold = $urandom_range(10, 60);
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		acct_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending, tdata %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("yield_now", 32'(want.yield_now), 32'(m_tdata[0]));
				check_field("demoted", 32'(want.demoted), 32'(m_tdata[1]));
				check_field("boosted", 32'(want.boosted), 32'(m_tdata[2]));
				check_field("level_after", 32'(want.level_after), 32'(m_tdata[4:3]));
				check_field("runtime_after", want.runtime_after, m_tdata[36:5]);
			end
		end
	end

	task automatic send_beat(logic [1:0] cmd, logic [SLOT_W-1:0] slot, logic running,
			logic boot);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {boot, running, slot};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(account_beat(cmd, slot, running, boot));
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BOOST_INTERVAL: boost_interval_r = value;
			REG_QUANTUM_HIGH: quantum_r[0] = value[7:0];
			REG_QUANTUM_MID: quantum_r[1] = value[7:0];
			REG_QUANTUM_LOW: quantum_r[2] = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_scheduler(logic [15:0] interval, logic [7:0] qh, logic [7:0] qm,
			logic [7:0] ql);
		write_reg(REG_BOOST_INTERVAL, interval);
		write_reg(REG_QUANTUM_HIGH, {8'd0, qh});
		write_reg(REG_QUANTUM_MID, {8'd0, qm});
		write_reg(REG_QUANTUM_LOW, {8'd0, ql});
	endtask

	task automatic test_directed();
		set_scheduler(16'd3, 8'd1, 8'd2, 8'd0);
		send_beat(CMD_USE, 6'd0, 1'b0, 1'b0);
		send_beat(CMD_USE, 6'd63, 1'b1, 1'b1);
		// walk slot 0 down all levels, zero quantum at the bottom
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b0);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b0);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b0);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b0);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b0);
		// boost lands on the third boot tick, then slot 63 is accounted
		send_beat(CMD_TICK, 6'd63, 1'b1, 1'b1);
		send_beat(CMD_TICK, 6'd0, 1'b0, 1'b1);
		send_beat(CMD_TICK, 6'd63, 1'b1, 1'b1);
		send_beat(CMD_TICK, 6'd0, 1'b0, 1'b0);
		// slot not in use still gets accounted
		send_beat(CMD_TICK, 6'd40, 1'b1, 1'b0);
		send_beat(CMD_TICK, 6'd40, 1'b1, 1'b1);
		send_beat(CMD_UNUSED, 6'd0, 1'b1, 1'b1);
		send_beat(CMD_UNUSED, 6'd40, 1'b0, 1'b0);
		send_beat(CMD_FREE, 6'd63, 1'b0, 1'b0);
		send_beat(CMD_FREE, 6'd40, 1'b1, 1'b1);
		settle_idle();
		// zero interval boosts on every boot tick
		set_scheduler(16'd0, 8'd255, 8'd1, 8'd1);
		send_beat(CMD_TICK, 6'd0, 1'b0, 1'b1);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b1);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b0);
		send_beat(CMD_TICK, 6'd0, 1'b1, 1'b1);
		send_beat(CMD_TICK, 6'd21, 1'b1, 1'b1);
		settle_idle();
	endtask

	task automatic random_beat(logic [SLOT_W-1:0] hot [4]);
		int               r;
		logic [1:0]       cmd;
		logic [SLOT_W-1:0] slot;
		r = $urandom_range(0, 99);
		if (r < 75)
			cmd = CMD_TICK;
		else if (r < 85)
			cmd = CMD_USE;
		else if (r < 95)
			cmd = CMD_FREE;
		else
			cmd = CMD_UNUSED;
		if ($urandom_range(0, 99) < ((cmd == CMD_TICK) ? 85 : 50))
			slot = hot[$urandom_range(0, 3)];
		else
			slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		send_beat(cmd, slot, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 70);
	endtask

	task automatic test_random_phases();
		logic [SLOT_W-1:0] hot [4];
		for (int phase = 0; phase < 6; phase++) begin
			settle_idle();
			case (phase)
				0: set_scheduler(BOOST_INTERVAL_RST, QUANTUM_HIGH_RST, QUANTUM_MID_RST,
					QUANTUM_LOW_RST);
				1: set_scheduler(16'd1, 8'd1, 8'd1, 8'd1);
				2: set_scheduler(16'hffff, 8'hff, 8'hff, 8'hff);
				default: set_scheduler(16'($urandom_range(2, 40)), 8'($urandom_range(1, 12)),
					8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
			endcase
			gaps_on = (phase != 0);
			stalls_on = (phase != 0) && (phase != 3);
			for (int k = 0; k < 4; k++) begin
				hot[k] = SLOT_W'($urandom_range(0, SLOTS - 1));
				send_beat(CMD_USE, hot[k], 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end
			for (int n = 0; n < 321; n++) begin
				random_beat(hot);
				// sender holds off until the pipe is empty
				if (n == 160 || $urandom_range(0, 99) == 0)
					settle_idle();
			end
		end
		gaps_on = 0;
		stalls_on = 0;
	endtask

	initial begin
		clear_scheduler();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		settle_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("mlfq_quantum_accounting verification clean");
		else
			$display("mlfq_quantum_accounting verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mqa_pkg.sv
design/mqa_ram.sv
design/mlfq_quantum_accounting.sv
test/tb.sv
